/* rtl/ppsc_pkg.sv */
// ----------------------------------------------------------------------------
// ppsc_pkg
// Shared types and constants for the packet statistics counter block.
// ----------------------------------------------------------------------------
package ppsc_pkg;

  // verdict codes
  localparam logic [1:0] VERDICT_OK    = 2'd0;
  localparam logic [1:0] VERDICT_FRAG  = 2'd1;
  localparam logic [1:0] VERDICT_CKSUM = 2'd2;
  localparam logic [1:0] VERDICT_DROP  = 2'd3;

  // packet kind codes
  localparam logic [1:0] KIND_IN    = 2'd0;
  localparam logic [1:0] KIND_OUT   = 2'd1;
  localparam logic [1:0] KIND_BCAST = 2'd2;

  // layer-3 codes
  localparam logic [1:0] L3_IPV4 = 2'd0;
  localparam logic [1:0] L3_IPV6 = 2'd1;

  // transport protocol numbers
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;

  // counter groups
  localparam logic [3:0] GRP_TOTAL = 4'd0;
  localparam logic [3:0] GRP_IPV4  = 4'd1;
  localparam logic [3:0] GRP_IPV6  = 4'd2;
  localparam logic [3:0] GRP_NONIP = 4'd3;
  localparam logic [3:0] GRP_BCAST = 4'd4;
  localparam logic [3:0] GRP_TCP   = 4'd5;
  localparam logic [3:0] GRP_UDP   = 4'd6;
  localparam logic [3:0] GRP_ICMP  = 4'd7;
  localparam logic [3:0] GRP_OTHER = 4'd8;
  localparam logic [3:0] GRP_BAD   = 4'd9;

  // counter fields
  localparam logic [2:0] FLD_BYTES     = 3'd1;
  localparam logic [2:0] FLD_IN_PKTS   = 3'd2;
  localparam logic [2:0] FLD_OUT_PKTS  = 3'd4;
  localparam logic [2:0] FLD_OUT_BYTES = 3'd5;

  localparam logic [16:0] V6_HDR_BYTES = 17'd40;

  // row stores: "all" rows one per group, directional rows two per group except the bad group
  localparam int A_ROWS  = 10;
  localparam int A_AW    = 4;
  localparam int B_ROWS  = 18;
  localparam int B_AW    = 5;
  localparam int LEN_W   = 17;
  localparam int OPS_MAX = 4;

  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic        mode;
    logic [1:0]  verdict;
    logic [1:0]  pkt_kind;
    logic [15:0] frame_len;
    logic [1:0]  l3_type;
    logic [15:0] ipv4_total_len;
    logic [15:0] ipv6_payload_len;
    logic [7:0]  ip_proto;
    logic [3:0]  counter_group;
    logic [2:0]  counter_field;
  } in_t;

  typedef struct packed {
    logic        counted;
    logic        checksum_bad;
    logic [63:0] read_value;
  } out_t;

  typedef struct packed {
    logic [3:0]       grp;
    logic [LEN_W-1:0] len;
  } op_t;

  typedef struct packed {
    logic                    is_read;
    logic                    counted;
    logic                    cksum_bad;
    logic                    outgoing;
    logic [2:0]              nops;
    op_t [OPS_MAX-1:0]       ops;
    logic                    rd_ok;
    logic                    rd_dir;
    logic                    rd_out;
    logic                    rd_bytes;
    logic [3:0]              rd_grp;
  } job_t;

endpackage

/* rtl/packet_protocol_stat_counters_top.sv */
// Each item waits in the job queue, then passes the issue stage (row read) and the
// update stage (add, write back) once per counter group; the last pass pushes the result.
// A packet does one group read-modify-write per cycle on the shared row stores, its last
// group waiting for room in the result queue; a read is a single pass.
// Reset: synchronous active-low; all counters read as zero after reset through
// per-row valid flags, with no clearing pass.
// ----------------------------------------------------------------------------
// packet_protocol_stat_counters_top
// Interface statistics counters: classify packets, bump wrapping counters,
// return one counter per read item.
// ----------------------------------------------------------------------------
module packet_protocol_stat_counters_top #(
  parameter int COUNTER_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  ppsc_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output ppsc_pkg::out_t out_data
);

  localparam int JW  = $bits(ppsc_pkg::job_t);
  localparam int OW  = $bits(ppsc_pkg::out_t);
  localparam int RCW = $clog2(ppsc_pkg::RES_DEPTH + 1);
  localparam int JCW = $clog2(ppsc_pkg::JOB_DEPTH + 1);

  ppsc_pkg::job_t  new_job, cur_job;
  logic            job_empty, job_pop;
  logic [JCW-1:0]  job_count;
  logic            res_push, res_full;
  logic [RCW-1:0]  res_count;
  ppsc_pkg::out_t  res_data;

  ppsc_front u_front (
    .item (in_data),
    .job  (new_job)
  );

  ppsc_fifo #(.WIDTH(JW), .DEPTH(ppsc_pkg::JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (new_job),
    .full  (in_full),
    .pop   (job_pop),
    .dout  (cur_job),
    .empty (job_empty),
    .count (job_count)
  );

  ppsc_back #(.COUNTER_BITS(COUNTER_BITS), .RES_DEPTH(ppsc_pkg::RES_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (cur_job),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  ppsc_fifo #(.WIDTH(OW), .DEPTH(ppsc_pkg::RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty),
    .count (res_count)
  );

  a_job_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  a_job_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_count <= JCW'(ppsc_pkg::JOB_DEPTH))
    else $error("job queue count out of range");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_drop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_data.counted) |-> !res_data.checksum_bad)
    else $error("checksum flag on uncounted item");

endmodule

/* rtl/ppsc_ram.sv */
// ----------------------------------------------------------------------------
// ppsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppsc_fifo.sv */
// ----------------------------------------------------------------------------
// ppsc_fifo
// Small flop-based queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module ppsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* rtl/ppsc_front.sv */
// ----------------------------------------------------------------------------
// ppsc_front
// Classifies one item into a job: the list of counter groups to bump with
// their byte counts, or the location of one counter to read.
// ----------------------------------------------------------------------------
module ppsc_front (
  input  ppsc_pkg::in_t  item,
  output ppsc_pkg::job_t job
);

  always_comb begin
    logic [2:0]       n;
    logic             transport;
    logic [ppsc_pkg::LEN_W-1:0] flen;
    logic [ppsc_pkg::LEN_W-1:0] iplen;

    job       = '0;
    n         = '0;
    transport = 1'b0;
    flen      = ppsc_pkg::LEN_W'(item.frame_len);
    iplen     = '0;

    if (item.mode) begin
      job.is_read  = 1'b1;
      job.rd_grp   = item.counter_group;
      job.rd_dir   = (item.counter_field >= ppsc_pkg::FLD_IN_PKTS);
      job.rd_out   = (item.counter_field >= ppsc_pkg::FLD_OUT_PKTS);
      job.rd_bytes = item.counter_field[0];
      job.rd_ok    = ((item.counter_group <= ppsc_pkg::GRP_OTHER) &&
                      (item.counter_field <= ppsc_pkg::FLD_OUT_BYTES)) ||
                     ((item.counter_group == ppsc_pkg::GRP_BAD) &&
                      (item.counter_field <= ppsc_pkg::FLD_BYTES));
    end else if (item.verdict != ppsc_pkg::VERDICT_DROP) begin
      job.counted  = 1'b1;
      job.outgoing = (item.pkt_kind == ppsc_pkg::KIND_OUT);

      job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_TOTAL, len: flen};
      n = n + 3'd1;
      if (item.pkt_kind == ppsc_pkg::KIND_BCAST) begin
        job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_BCAST, len: flen};
        n = n + 3'd1;
      end

      if (item.l3_type == ppsc_pkg::L3_IPV4) begin
        if (item.verdict == ppsc_pkg::VERDICT_CKSUM) begin
          job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_BAD, len: flen};
          n = n + 3'd1;
          job.cksum_bad = 1'b1;
        end else begin
          iplen = ppsc_pkg::LEN_W'(item.ipv4_total_len);
          job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_IPV4, len: iplen};
          n = n + 3'd1;
          transport = 1'b1;
        end
      end else if (item.l3_type == ppsc_pkg::L3_IPV6) begin
        iplen = ppsc_pkg::LEN_W'(item.ipv6_payload_len) + ppsc_pkg::V6_HDR_BYTES;
        job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_IPV6, len: iplen};
        n = n + 3'd1;
        transport = 1'b1;
      end else begin
        job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_NONIP, len: flen};
        n = n + 3'd1;
      end

      if (transport) begin
        case (item.ip_proto)
          ppsc_pkg::PROTO_TCP:
            job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_TCP, len: iplen};
          ppsc_pkg::PROTO_UDP:
            job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_UDP, len: iplen};
          ppsc_pkg::PROTO_ICMP, ppsc_pkg::PROTO_ICMP6:
            job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_ICMP, len: iplen};
          default:
            job.ops[n[1:0]] = '{grp: ppsc_pkg::GRP_OTHER, len: iplen};
        endcase
        n = n + 3'd1;
      end
      job.nops = n;
    end
  end

endmodule

/* rtl/ppsc_back.sv */
// ----------------------------------------------------------------------------
// ppsc_back
// Steps through a job one counter group per cycle (the last waits for result space):
// read the group's rows, then add and write back next cycle, forwarding back-to-back hits.
// ----------------------------------------------------------------------------
module ppsc_back #(
  parameter int COUNTER_BITS = 64,
  parameter int RES_DEPTH = 4,
  localparam int RCW = $clog2(RES_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ppsc_pkg::job_t   job,
  input  logic             job_valid,
  output logic             job_pop,
  input  logic [RCW-1:0]   res_count,
  output logic             res_push,
  output ppsc_pkg::out_t   res_data
);

  localparam int RW = 2 * COUNTER_BITS;
  localparam int AAW = ppsc_pkg::A_AW;
  localparam int BAW = ppsc_pkg::B_AW;

  // issue stage
  logic [1:0]         idx_r, idx_nxt;
  ppsc_pkg::op_t      op;
  logic               last, fire, upd, room;
  logic [AAW-1:0]     ra_a;
  logic [BAW-1:0]     ra_b;

  // update stage
  logic               s2_vld_r, s2_last_r, s2_upd_r, s2_dir_r;
  logic               s2_read_r, s2_rd_ok_r, s2_rd_dir_r, s2_rd_bytes_r;
  logic               s2_counted_r, s2_cksum_r;
  logic [ppsc_pkg::LEN_W-1:0] s2_len_r;
  logic [AAW-1:0]     s2_wa_a_r;
  logic [BAW-1:0]     s2_wa_b_r;

  logic [RW-1:0]      q_a, q_b, cur_a, cur_b, wd_a, wd_b, sel_row;
  logic [COUNTER_BITS-1:0] sel_val;
  logic               we_a, we_b;
  logic               fwd_a_r, fwd_b_r, vld_a_r, vld_b_r;
  logic [RW-1:0]      fwd_da_r, fwd_db_r;
  logic [ppsc_pkg::A_ROWS-1:0] valid_a_r;
  logic [ppsc_pkg::B_ROWS-1:0] valid_b_r;

  // ---- issue ----
  assign op   = job.ops[idx_r];
  assign last = job.is_read || (job.nops <= 3'd1) || ({1'b0, idx_r} + 3'd1 == job.nops);
  // last slot needs a free result entry, counting the one still in flight
  assign room = ({1'b0, res_count} + (RCW + 1)'(s2_vld_r && s2_last_r)) <
                (RCW + 1)'(RES_DEPTH);
  assign fire    = job_valid && (!last || room);
  assign job_pop = fire && last;
  assign upd     = fire && !job.is_read && (job.nops != 3'd0);

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
    if (job.is_read) begin
      ra_a = job.rd_ok ? job.rd_grp[AAW-1:0] : '0;
      ra_b = (job.rd_ok && job.rd_dir) ? {job.rd_grp, job.rd_out} : '0;
    end else begin
      ra_a = op.grp[AAW-1:0];
      ra_b = (op.grp != ppsc_pkg::GRP_BAD) ? {op.grp, job.outgoing} : '0;
    end
  end

  // ---- update ----
  assign cur_a = fwd_a_r ? fwd_da_r : (vld_a_r ? q_a : '0);
  assign cur_b = fwd_b_r ? fwd_db_r : (vld_b_r ? q_b : '0);
  assign wd_a  = {cur_a[RW-1:COUNTER_BITS] + COUNTER_BITS'(1),
                  cur_a[COUNTER_BITS-1:0] + COUNTER_BITS'(s2_len_r)};
  assign wd_b  = {cur_b[RW-1:COUNTER_BITS] + COUNTER_BITS'(1),
                  cur_b[COUNTER_BITS-1:0] + COUNTER_BITS'(s2_len_r)};
  assign we_a  = s2_vld_r && s2_upd_r;
  assign we_b  = s2_vld_r && s2_upd_r && s2_dir_r;

  assign sel_row = s2_rd_dir_r ? cur_b : cur_a;
  assign sel_val = s2_rd_bytes_r ? sel_row[COUNTER_BITS-1:0] : sel_row[RW-1:COUNTER_BITS];

  assign res_push              = s2_vld_r && s2_last_r;
  assign res_data.counted      = s2_counted_r;
  assign res_data.checksum_bad = s2_cksum_r;
  assign res_data.read_value   = (s2_read_r && s2_rd_ok_r) ? 64'(sel_val) : '0;

  ppsc_ram #(.WIDTH(RW), .DEPTH(ppsc_pkg::A_ROWS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (s2_wa_a_r),
    .wdata (wd_a),
    .raddr (ra_a),
    .rdata (q_a)
  );

  ppsc_ram #(.WIDTH(RW), .DEPTH(ppsc_pkg::B_ROWS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (s2_wa_b_r),
    .wdata (wd_b),
    .raddr (ra_b),
    .rdata (q_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      s2_vld_r  <= 1'b0;
      fwd_a_r   <= 1'b0;
      fwd_b_r   <= 1'b0;
      valid_a_r <= '0;
      valid_b_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      s2_vld_r <= fire;
      // row written this cycle is read now: RAM returns old data, so bypass
      fwd_a_r  <= we_a && (s2_wa_a_r == ra_a);
      fwd_b_r  <= we_b && (s2_wa_b_r == ra_b);
      if (we_a) begin
        valid_a_r[s2_wa_a_r] <= 1'b1;
      end
      if (we_b) begin
        valid_b_r[s2_wa_b_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r     <= last;
    s2_upd_r      <= upd;
    s2_dir_r      <= (op.grp != ppsc_pkg::GRP_BAD);
    s2_read_r     <= job.is_read;
    s2_rd_ok_r    <= job.rd_ok;
    s2_rd_dir_r   <= job.rd_dir;
    s2_rd_bytes_r <= job.rd_bytes;
    s2_counted_r  <= job.counted;
    s2_cksum_r    <= job.cksum_bad;
    s2_len_r      <= op.len;
    s2_wa_a_r     <= ra_a;
    s2_wa_b_r     <= ra_b;
    vld_a_r       <= valid_a_r[ra_a];
    vld_b_r       <= valid_b_r[ra_b];
    fwd_da_r      <= wd_a;
    fwd_db_r      <= wd_b;
  end

endmodule

/* bench/packet_protocol_stat_counters_top_tb.sv */
// ----------------------------------------------------------------------------
// packet_protocol_stat_counters_top_tb
// Drives packet and counter-read items into the statistics block, keeps its
// own copy of the 56 counters to predict every result, and compares each
// popped result field by field. Both queue sides idle at random, and one
// long receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module packet_protocol_stat_counters_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CNT_BITS     = 64;
  localparam logic [63:0] CNT_MASK     = {64{1'b1}} >> (64 - CNT_BITS);
  localparam int          NUM_COUNTERS = 56;
  localparam int          BAD_BASE     = 54;
  localparam int          GROUP_STRIDE = 6;

  localparam logic       MODE_ACCOUNT  = 1'b0;
  localparam logic       MODE_READ     = 1'b1;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [1:0] L3_NONIP      = 2'd2;
  localparam logic [1:0] L3_UNUSED     = 2'd3;
  localparam logic [2:0] FLD_PKTS      = 3'd0;
  localparam logic [2:0] FLD_IN_BYTES  = 3'd3;
  localparam logic [2:0] FLD_UNUSED_LO = 3'd6;
  localparam logic [2:0] FLD_UNUSED_HI = 3'd7;
  localparam logic [3:0] GRP_UNUSED_LO = 4'd10;
  localparam logic [3:0] GRP_UNUSED_HI = 4'd15;
  localparam logic [7:0] PROTO_ZERO    = 8'd0;
  localparam logic [7:0] PROTO_MAX     = 8'd255;

  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int RANDOM_CHUNKS = 6;
  localparam int FILL_ITEMS    = 40;
  localparam int REPORT_MAX    = 10;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_push;
  logic           in_full;
  ppsc_pkg::in_t  in_data;
  logic           out_empty;
  logic           out_pop = 1'b0;
  ppsc_pkg::out_t out_data;

  logic [63:0]    stat_counters [NUM_COUNTERS];
  ppsc_pkg::out_t replies_due [$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  logic           gaps_on = 1'b1;
  int             hold_epoch = 0;
  int             seen_epoch = 0;
  int             hold_left = 0;
  int             pop_gap = 0;

  packet_protocol_stat_counters_top #(
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void bump_pair(input int idx, input logic [63:0] bytes);
    if (idx + 1 >= NUM_COUNTERS) return;
    stat_counters[idx]     = (stat_counters[idx] + 64'd1) & CNT_MASK;
    stat_counters[idx + 1] = (stat_counters[idx + 1] + bytes) & CNT_MASK;
  endfunction

  function automatic void bump_group(input logic [3:0] grp, input logic outgoing,
                                     input logic [63:0] bytes);
    int base;
    base = int'(grp) * GROUP_STRIDE;
    bump_pair(base + int'(FLD_PKTS), bytes);
    bump_pair(base + int'(outgoing ? ppsc_pkg::FLD_OUT_PKTS : ppsc_pkg::FLD_IN_PKTS),
              bytes);
  endfunction

  function automatic ppsc_pkg::out_t predict_stats(input ppsc_pkg::in_t item);
    ppsc_pkg::out_t r;
    logic           outgoing;
    logic [63:0]    flen;
    logic [63:0]    ip_bytes;
    logic [3:0]     l4_grp;
    r = '0;
    if (item.mode == MODE_READ) begin
      if (item.counter_group <= ppsc_pkg::GRP_OTHER &&
          item.counter_field <= ppsc_pkg::FLD_OUT_BYTES)
        r.read_value = stat_counters[int'(item.counter_group) * GROUP_STRIDE +
                                     int'(item.counter_field)];
      else if (item.counter_group == ppsc_pkg::GRP_BAD &&
               item.counter_field <= ppsc_pkg::FLD_BYTES)
        r.read_value = stat_counters[BAD_BASE + int'(item.counter_field)];
      return r;
    end
    if (item.verdict == ppsc_pkg::VERDICT_DROP) return r;

    r.counted = 1'b1;
    outgoing  = (item.pkt_kind == ppsc_pkg::KIND_OUT);
    flen      = 64'(item.frame_len);
    bump_group(ppsc_pkg::GRP_TOTAL, outgoing, flen);
    if (item.pkt_kind == ppsc_pkg::KIND_BCAST) bump_group(ppsc_pkg::GRP_BCAST, outgoing, flen);

    if (item.l3_type == ppsc_pkg::L3_IPV4) begin
      if (item.verdict == ppsc_pkg::VERDICT_CKSUM) begin
        bump_pair(BAD_BASE, flen);
        r.checksum_bad = 1'b1;
        return r;
      end
      ip_bytes = 64'(item.ipv4_total_len);
      bump_group(ppsc_pkg::GRP_IPV4, outgoing, ip_bytes);
    end else if (item.l3_type == ppsc_pkg::L3_IPV6) begin
      ip_bytes = 64'(item.ipv6_payload_len) + 64'(ppsc_pkg::V6_HDR_BYTES);
      bump_group(ppsc_pkg::GRP_IPV6, outgoing, ip_bytes);
    end else begin
      // non-IP and the unused layer-3 code: no transport class
      bump_group(ppsc_pkg::GRP_NONIP, outgoing, flen);
      return r;
    end

    case (item.ip_proto)
      ppsc_pkg::PROTO_TCP:                         l4_grp = ppsc_pkg::GRP_TCP;
      ppsc_pkg::PROTO_UDP:                         l4_grp = ppsc_pkg::GRP_UDP;
      ppsc_pkg::PROTO_ICMP, ppsc_pkg::PROTO_ICMP6: l4_grp = ppsc_pkg::GRP_ICMP;
      default:                                     l4_grp = ppsc_pkg::GRP_OTHER;
    endcase
    bump_group(l4_grp, outgoing, ip_bytes);
    return r;
  endfunction

  // ----------------------------------------------------------- item builders

  function automatic ppsc_pkg::in_t make_packet(input logic [1:0] verdict,
                                                input logic [1:0] kind,
                                                input logic [1:0] l3,
                                                input logic [7:0] proto,
                                                input logic [15:0] flen,
                                                input logic [15:0] v4len,
                                                input logic [15:0] v6len);
    ppsc_pkg::in_t it;
    it.mode             = MODE_ACCOUNT;
    it.verdict          = verdict;
    it.pkt_kind         = kind;
    it.frame_len        = flen;
    it.l3_type          = l3;
    it.ipv4_total_len   = v4len;
    it.ipv6_payload_len = v6len;
    it.ip_proto         = proto;
    it.counter_group    = 4'($urandom_range(0, 15));
    it.counter_field    = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic ppsc_pkg::in_t make_read(input logic [3:0] grp, input logic [2:0] fld);
    ppsc_pkg::in_t it;
    logic [95:0]   raw;
    raw              = {$urandom, $urandom, $urandom};
    it               = raw[$bits(ppsc_pkg::in_t)-1:0];
    it.mode          = MODE_READ;
    it.counter_group = grp;
    it.counter_field = fld;
    return it;
  endfunction

  function automatic logic [15:0] random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 50) return 16'($urandom_range(0, 1600));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic ppsc_pkg::in_t random_item();
    int          r;
    logic [1:0]  verdict;
    logic [1:0]  kind;
    logic [1:0]  l3;
    logic [7:0]  proto;
    logic [3:0]  grp;
    logic [2:0]  fld;
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 85) grp = 4'($urandom_range(0, 9));
      else grp = 4'($urandom_range(10, 15));
      if (grp == ppsc_pkg::GRP_BAD && $urandom_range(0, 1) == 0)
        fld = 3'($urandom_range(0, 1));
      else if ($urandom_range(0, 99) < 85) fld = 3'($urandom_range(0, 5));
      else fld = 3'($urandom_range(6, 7));
      return make_read(grp, fld);
    end
    r = $urandom_range(0, 99);
    verdict = (r < 50) ? ppsc_pkg::VERDICT_OK : (r < 65) ? ppsc_pkg::VERDICT_FRAG :
              (r < 85) ? ppsc_pkg::VERDICT_CKSUM : ppsc_pkg::VERDICT_DROP;
    r = $urandom_range(0, 99);
    kind = (r < 45) ? ppsc_pkg::KIND_IN : (r < 80) ? ppsc_pkg::KIND_OUT :
           (r < 95) ? ppsc_pkg::KIND_BCAST : KIND_UNUSED;
    r = $urandom_range(0, 99);
    l3 = (r < 45) ? ppsc_pkg::L3_IPV4 : (r < 80) ? ppsc_pkg::L3_IPV6 :
         (r < 95) ? L3_NONIP : L3_UNUSED;
    r = $urandom_range(0, 99);
    proto = (r < 25) ? ppsc_pkg::PROTO_TCP : (r < 50) ? ppsc_pkg::PROTO_UDP :
            (r < 60) ? ppsc_pkg::PROTO_ICMP : (r < 70) ? ppsc_pkg::PROTO_ICMP6 :
            8'($urandom_range(0, 255));
    return make_packet(verdict, kind, l3, proto, random_len(), random_len(), random_len());
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ------------------------------------------------------------------ sender

  // in_push stays high into the next call when no gap follows
  task automatic send_item(input ppsc_pkg::in_t item);
    int gap;
    in_push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_full) @(posedge clk);
    replies_due.push_back(predict_stats(item));
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ------------------------------------------------------- receiver / checker

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    ppsc_pkg::out_t want;
    logic           took;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      took = out_pop && !out_empty;
      if (took) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, out_data.read_value);
        end else begin
          want = replies_due.pop_front();
          if (out_data.counted !== want.counted)
            report_mismatch("counted", 64'(want.counted), 64'(out_data.counted));
          if (out_data.checksum_bad !== want.checksum_bad)
            report_mismatch("checksum_bad", 64'(want.checksum_bad),
                            64'(out_data.checksum_bad));
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, out_data.read_value);
        end
        pop_gap = pick_gap();
      end
      if (hold_epoch != seen_epoch) begin
        seen_epoch = hold_epoch;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------- tests

  task automatic test_directed_packets();
    // counters read zero right after reset
    send_item(make_read(ppsc_pkg::GRP_TOTAL, FLD_PKTS));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_IN, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_TCP, 16'h0000, 16'h0000, 16'h0000));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_OUT, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_UDP, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_packet(ppsc_pkg::VERDICT_FRAG, ppsc_pkg::KIND_BCAST, ppsc_pkg::L3_IPV6,
                          ppsc_pkg::PROTO_ICMP, 16'd1500, 16'd20, 16'hFFFF));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_IN, ppsc_pkg::L3_IPV6,
                          ppsc_pkg::PROTO_ICMP6, 16'd64, 16'd0, 16'd0));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_IN, ppsc_pkg::L3_IPV4,
                          PROTO_ZERO, 16'd60, 16'd46, 16'd7));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_OUT, ppsc_pkg::L3_IPV6,
                          PROTO_MAX, 16'd90, 16'd3, 16'd50));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_BCAST, L3_NONIP,
                          ppsc_pkg::PROTO_TCP, 16'd42, 16'd9, 16'd9));
    // IPv4 checksum errors land in the bad group instead of the layer-3 and transport groups
    send_item(make_packet(ppsc_pkg::VERDICT_CKSUM, ppsc_pkg::KIND_IN, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_TCP, 16'd100, 16'd86, 16'd0));
    send_item(make_packet(ppsc_pkg::VERDICT_CKSUM, ppsc_pkg::KIND_BCAST, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_UDP, 16'hFFFF, 16'd1, 16'd0));
    // checksum error outside IPv4 counts as a normal packet
    send_item(make_packet(ppsc_pkg::VERDICT_CKSUM, ppsc_pkg::KIND_OUT, ppsc_pkg::L3_IPV6,
                          ppsc_pkg::PROTO_TCP, 16'd200, 16'd0, 16'd160));
    send_item(make_packet(ppsc_pkg::VERDICT_CKSUM, ppsc_pkg::KIND_IN, L3_NONIP,
                          ppsc_pkg::PROTO_UDP, 16'd70, 16'd0, 16'd0));
    send_item(make_packet(ppsc_pkg::VERDICT_DROP, ppsc_pkg::KIND_IN, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_TCP, 16'd300, 16'd280, 16'd0));
    // unused kind and layer-3 codes
    send_item(make_packet(ppsc_pkg::VERDICT_OK, KIND_UNUSED, ppsc_pkg::L3_IPV4,
                          ppsc_pkg::PROTO_TCP, 16'd128, 16'd100, 16'd0));
    send_item(make_packet(ppsc_pkg::VERDICT_OK, ppsc_pkg::KIND_IN, L3_UNUSED,
                          ppsc_pkg::PROTO_UDP, 16'd256, 16'd1, 16'd2));
  endtask

  task automatic test_counter_reads();
    send_item(make_read(ppsc_pkg::GRP_TOTAL, ppsc_pkg::FLD_BYTES));
    send_item(make_read(ppsc_pkg::GRP_BCAST, ppsc_pkg::FLD_IN_PKTS));
    send_item(make_read(ppsc_pkg::GRP_IPV6, ppsc_pkg::FLD_OUT_BYTES));
    send_item(make_read(ppsc_pkg::GRP_BAD, FLD_PKTS));
    send_item(make_read(ppsc_pkg::GRP_BAD, ppsc_pkg::FLD_BYTES));
    // invalid selections read as zero
    send_item(make_read(ppsc_pkg::GRP_BAD, ppsc_pkg::FLD_IN_PKTS));
    send_item(make_read(ppsc_pkg::GRP_BAD, ppsc_pkg::FLD_OUT_BYTES));
    send_item(make_read(ppsc_pkg::GRP_TCP, FLD_UNUSED_LO));
    send_item(make_read(ppsc_pkg::GRP_NONIP, FLD_UNUSED_HI));
    send_item(make_read(GRP_UNUSED_LO, FLD_IN_BYTES));
    send_item(make_read(GRP_UNUSED_HI, ppsc_pkg::FLD_OUT_PKTS));
  endtask

  task automatic test_random_traffic();
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      gaps_on <= (c % 2 == 0);
      for (int i = 0; i < RANDOM_ITEMS / RANDOM_CHUNKS; i++) send_item(random_item());
    end
    gaps_on <= 1'b1;
  endtask

  // receiver stops popping for a long stretch while the sender keeps offering;
  // gaps come back on with the next test
  task automatic test_output_stall();
    gaps_on    <= 1'b0;
    hold_epoch <= hold_epoch + 1;
    for (int i = 0; i < FILL_ITEMS; i++) send_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < NUM_COUNTERS; i++) stat_counters[i] = 64'd0;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_packets();
    test_counter_reads();
    test_output_stall();
    test_random_traffic();

    in_push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
